// ===== design/codon_histogram_counter_assert.svh =====
// Assertion macros shared by the codon histogram RTL.
// Each macro expects clk and arst_n in scope; checks are off while reset is low.
`ifndef CODON_HISTOGRAM_COUNTER_ASSERT_SVH
`define CODON_HISTOGRAM_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define CHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/chc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

	localparam int SYMBOL_W    = 8;
	localparam int BIN_W       = 6;
	localparam int NUM_BINS    = 64;
	localparam int CODE_W      = 2;
	localparam int RUN_W       = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int COUNT_OUT_W = 32;
	localparam int OUT_TDATA_W = 40;

	// nucleotide letters
	localparam logic [SYMBOL_W-1:0] CH_A_UP = 8'h41;
	localparam logic [SYMBOL_W-1:0] CH_A_LO = 8'h61;
	localparam logic [SYMBOL_W-1:0] CH_C_UP = 8'h43;
	localparam logic [SYMBOL_W-1:0] CH_C_LO = 8'h63;
	localparam logic [SYMBOL_W-1:0] CH_G_UP = 8'h47;
	localparam logic [SYMBOL_W-1:0] CH_G_LO = 8'h67;
	localparam logic [SYMBOL_W-1:0] CH_T_UP = 8'h54;
	localparam logic [SYMBOL_W-1:0] CH_T_LO = 8'h74;

	localparam logic [CODE_W-1:0] CODE_A = 2'd0;
	localparam logic [CODE_W-1:0] CODE_C = 2'd1;
	localparam logic [CODE_W-1:0] CODE_G = 2'd2;
	localparam logic [CODE_W-1:0] CODE_T = 2'd3;

	// window fill level saturates here
	localparam logic [RUN_W-1:0] RUN_FULL = 2'd2;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_READ = 1'b1
	} mode_t;

	typedef struct packed {
		logic             hit;
		logic [BIN_W-1:0] idx;
	} codon_t;

endpackage

`default_nettype wire

// ===== design/chc_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module chc_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [chc_pkg::SYMBOL_W-1:0]   symbol,
	input  logic                           new_sequence,
	output chc_pkg::codon_t                codon
);

	logic [chc_pkg::CODE_W-1:0] prev_one_q;
	logic [chc_pkg::CODE_W-1:0] prev_two_q;
	logic [chc_pkg::RUN_W-1:0]  run_q;
	logic [chc_pkg::RUN_W-1:0]  run_eff;
	logic [chc_pkg::CODE_W-1:0] code;
	logic                       code_ok;

	always_comb begin
		code_ok = 1'b1;
		case (symbol)
			chc_pkg::CH_A_UP, chc_pkg::CH_A_LO: code = chc_pkg::CODE_A;
			chc_pkg::CH_C_UP, chc_pkg::CH_C_LO: code = chc_pkg::CODE_C;
			chc_pkg::CH_G_UP, chc_pkg::CH_G_LO: code = chc_pkg::CODE_G;
			chc_pkg::CH_T_UP, chc_pkg::CH_T_LO: code = chc_pkg::CODE_T;
			default: begin
				code    = chc_pkg::CODE_A;
				code_ok = 1'b0;
			end
		endcase
	end

	// new sequence drops the window before this letter is taken
	assign run_eff = new_sequence ? '0 : run_q;

	always_comb begin
		codon.hit = code_ok && (run_eff == chc_pkg::RUN_FULL);
		codon.idx = {code, prev_one_q, prev_two_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_one_q <= '0;
			prev_two_q <= '0;
			run_q      <= '0;
		end else if (step) begin
			if (!code_ok) begin
				run_q <= '0;
			end else begin
				prev_two_q <= prev_one_q;
				prev_one_q <= code;
				run_q      <= (run_eff == chc_pkg::RUN_FULL) ? run_eff : run_eff + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/chc_hist_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module chc_hist_mem #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [chc_pkg::BIN_W-1:0]   rd_addr,
	output logic [COUNT_WIDTH-1:0]      rd_data,
	input  logic                        wr_en,
	input  logic [chc_pkg::BIN_W-1:0]   wr_addr,
	input  logic [COUNT_WIDTH-1:0]      wr_data
);

	logic [COUNT_WIDTH-1:0]       mem_q [chc_pkg::NUM_BINS];
	logic [chc_pkg::NUM_BINS-1:0] vld_q;
	logic [COUNT_WIDTH-1:0]       rd_data_s2;

	// per-bin valid: an unwritten bin reads as zero, so reset clears all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// write-first bypass covers back-to-back hits on the same bin
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_s2 <= wr_data;
			end else if (!vld_q[rd_addr]) begin
				rd_data_s2 <= '0;
			end else begin
				rd_data_s2 <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_s2;

endmodule

`default_nettype wire

// ===== design/codon_histogram_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each input beat passes the input register, then the result register, to become a result beat.
// Throughput: one beat per cycle while m_tready is high; the histogram read/increment/write
// loop has a write-first bypass on a single-port-read memory, so hits on one bin never stall.
// Reset (arst_n low, async): clears the window state, the pipeline valids and the
// 64 per-bin valid flags at once; the histogram reads as zero with no clearing pass.

`include "codon_histogram_counter_assert.svh"

module codon_histogram_counter #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] symbol, [8] new_sequence, [14:9] bin, [15] zero
	input  logic [chc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [0] mode (0 push character, 1 read bin)
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] counted, [6:1] codon_index, [38:7] count, [39] zero
	output logic [chc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int RW = (COUNT_WIDTH < chc_pkg::COUNT_OUT_W) ? COUNT_WIDTH
		: chc_pkg::COUNT_OUT_W;

	// stage 1: input register
	logic                          valid_s1;
	chc_pkg::mode_t                mode_s1;
	logic [chc_pkg::SYMBOL_W-1:0]  symbol_s1;
	logic                          newseq_s1;
	logic [chc_pkg::BIN_W-1:0]     bin_s1;

	// stage 2: result register (count data lives in the memory read register)
	logic                          valid_s2;
	chc_pkg::mode_t                mode_s2;
	logic                          hit_s2;
	logic [chc_pkg::BIN_W-1:0]     idx_s2;

	logic                          adv;
	logic                          step;
	chc_pkg::codon_t               codon;
	logic                          rd_en;
	logic [chc_pkg::BIN_W-1:0]     rd_addr;
	logic [COUNT_WIDTH-1:0]        rd_data;
	logic                          wr_en;
	logic [COUNT_WIDTH-1:0]        wr_data;
	logic [chc_pkg::COUNT_OUT_W-1:0] count_out;

	// whole pipe moves when the result register is empty or being drained
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			mode_s1   <= chc_pkg::mode_t'(s_tuser);
			symbol_s1 <= s_tdata[7:0];
			newseq_s1 <= s_tdata[8];
			bin_s1    <= s_tdata[14:9];
		end
	end

	// window state advances only on push beats leaving stage 1
	assign step = valid_s1 && adv && (mode_s1 == chc_pkg::MODE_PUSH);

	chc_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.symbol       (symbol_s1),
		.new_sequence (newseq_s1),
		.codon        (codon)
	);

	// one read per beat: the requested bin on reads, the codon bin on pushes
	assign rd_en   = valid_s1 && adv;
	assign rd_addr = (mode_s1 == chc_pkg::MODE_READ) ? bin_s1 : codon.idx;

	// increment with saturation, written back as the beat leaves stage 2
	assign wr_en   = valid_s2 && hit_s2 && adv;
	assign wr_data = (&rd_data) ? rd_data : rd_data + 1'b1;

	chc_hist_mem #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_hist_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_s2),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			hit_s2  <= (mode_s1 == chc_pkg::MODE_PUSH) && codon.hit;
			idx_s2  <= ((mode_s1 == chc_pkg::MODE_PUSH) && codon.hit) ? codon.idx : '0;
		end
	end

	// only the low 32 bits of a wide counter are reported
	assign count_out = (mode_s2 == chc_pkg::MODE_READ)
		? chc_pkg::COUNT_OUT_W'(rd_data[RW-1:0]) : '0;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, count_out, idx_s2, hit_s2};

	`CHC_ASSERT_NOW(a_wr_only_on_leave, wr_en, valid_s2 && hit_s2 && m_tready,
		"histogram write without a counted beat leaving")
	`CHC_ASSERT_NOW(a_no_wrap, wr_en, wr_data != '0, "bin counter wrapped to zero")
	`CHC_ASSERT_NOW(a_ready_when_empty, !valid_s2, s_tready,
		"input stalled with an empty result register")
	`CHC_ASSERT_NEXT(a_count_holds, valid_s2 && !m_tready, $stable(rd_data),
		"count changed under a stalled result beat")

endmodule

`default_nettype wire
